### rtl/sstd_pkg.sv
// Shared types, constants and the segment font for the seven-segment text display controller.
// Used by the controller, the datapath and the top level; depends on nothing else.
package sstd_pkg;

    localparam int DIGITS = 16;
    localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_CLEAR   = 2'd1;
    localparam logic [1:0] OP_REFRESH = 2'd2;

    localparam logic [2:0] K_ACK   = 3'd0;
    localparam logic [2:0] K_DATA  = 3'd1;
    localparam logic [2:0] K_ADDR  = 3'd2;
    localparam logic [2:0] K_DIGIT = 3'd3;
    localparam logic [2:0] K_CTRL  = 3'd4;

    localparam logic [7:0] CMD_DATA  = 8'h40;
    localparam logic [7:0] CMD_ADDR  = 8'hC0;
    localparam logic [7:0] CMD_CTRL  = 8'h80;
    localparam logic [7:0] CTRL_ON   = 8'h08;
    localparam logic [7:0] POINT_CH  = 8'h2E;
    localparam logic [7:0] FIRST_PR  = 8'h20;
    localparam logic [7:0] LAST_PR   = 8'h7E;

    localparam logic [4:0] DIGIT_COUNT_RST = 5'd16;
    localparam logic [2:0] BRIGHTNESS_RST  = 3'd7;
    localparam logic       REG_DIGIT_COUNT = 1'b0;
    localparam logic       REG_BRIGHTNESS  = 1'b1;

    localparam logic [7:0] SEG_FONT [0:94] = '{
        8'h00, 8'h86, 8'h22, 8'h7E, 8'h6D, 8'h00, 8'h00, 8'h02,
        8'h30, 8'h06, 8'h63, 8'h00, 8'h04, 8'h40, 8'h80, 8'h52,
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07,
        8'h7F, 8'h6F, 8'h00, 8'h00, 8'h00, 8'h48, 8'h00, 8'h53,
        8'h5F, 8'h77, 8'h7F, 8'h39, 8'h3F, 8'h79, 8'h71, 8'h3D,
        8'h76, 8'h06, 8'h1E, 8'h69, 8'h38, 8'h15, 8'h37, 8'h3F,
        8'h73, 8'h67, 8'h31, 8'h6D, 8'h78, 8'h3E, 8'h2A, 8'h1D,
        8'h76, 8'h6E, 8'h5B, 8'h39, 8'h64, 8'h0F, 8'h00, 8'h08,
        8'h20, 8'h5F, 8'h7C, 8'h58, 8'h5E, 8'h7B, 8'h31, 8'h6F,
        8'h74, 8'h04, 8'h0E, 8'h75, 8'h30, 8'h55, 8'h54, 8'h5C,
        8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h1C, 8'h2A, 8'h1D,
        8'h76, 8'h6E, 8'h47, 8'h46, 8'h06, 8'h70, 8'h01
    };

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] character;
        logic [3:0] start_position;
        logic       first_of_string;
    } t_in_item;

    typedef struct packed {
        logic       is_byte;
        logic [7:0] send_byte;
        logic       begins_frame;
        logic       ends_frame;
        logic [4:0] chars_used;
        logic       too_long;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic             apply;
        logic             load;
        logic [2:0]       kind;
        logic [IDX_W-1:0] idx;
    } t_cmd;

    typedef struct packed {
        logic [4:0] digits_used;
    } t_status;

    function automatic logic [7:0] seg_lookup(input logic [7:0] ch);
        logic [7:0] off;
        off = ch - FIRST_PR;
        if (ch >= FIRST_PR && ch <= LAST_PR) begin
            return SEG_FONT[off[6:0]];
        end
        return 8'h00;
    endfunction

endpackage

### rtl/sstd_ctrl.sv
// Sequencer for the display controller: input acceptance, result pacing, refresh byte order.
// Depends on sstd_pkg; drives the datapath through t_cmd and reads t_status.
module sstd_ctrl import sstd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_op,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_status    i_status,
    output t_cmd       o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic       r_state, n_state;
    logic [4:0] r_step, n_step;
    logic       r_out_valid, n_out_valid;
    logic       out_free;
    logic       in_accept;
    logic [4:0] digit_off;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign digit_off  = r_step - 5'd2;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.idx   = digit_off[IDX_W-1:0];
        if (out_free) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    o_cmd.apply = 1'b1;
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    if (i_op == OP_REFRESH) begin
                        o_cmd.kind = K_DATA;
                        n_state    = S_EMIT;
                        n_step     = 5'd1;
                    end else begin
                        o_cmd.kind = K_ACK;
                    end
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_step      = r_step + 5'd1;
                    if (r_step == 5'd1) begin
                        o_cmd.kind = K_ADDR;
                    end else if (digit_off < i_status.digits_used) begin
                        o_cmd.kind = K_DIGIT;
                    end else begin
                        o_cmd.kind = K_CTRL;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_out_valid)
        else $error("accepted item produced no result");

    a_emit_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> o_in_stall)
        else $error("input taken during refresh");

    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_step != 5'd0 && r_step <= i_status.digits_used + 5'd2))
        else $error("refresh step out of range");

    a_ctrl_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load && o_cmd.kind == K_CTRL) |=> (r_state == S_IDLE))
        else $error("refresh did not end after control byte");

endmodule

### rtl/sstd_datapath.sv
// Datapath of the display controller: digit buffer, string cursor state and result register.
// Depends on sstd_pkg; commanded by sstd_ctrl through t_cmd.
module sstd_datapath import sstd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_data,
    input  t_cmd       i_cmd,
    input  logic [4:0] i_digit_count,
    input  logic [2:0] i_brightness,
    output t_status    o_status,
    output t_out_item  o_out_data
);

    logic [7:0]       r_digit [DIGITS];
    logic [4:0]       r_cursor, n_cursor;
    logic [3:0]       r_origin, n_origin;
    logic             r_ovf, n_ovf;
    t_out_item        r_out, n_out;

    logic [4:0]       n_used;
    logic [4:0]       eff_cur;
    logic [3:0]       eff_org;
    logic             eff_ovf;
    logic [4:0]       pos;
    logic             wr_en, pt_en, clr;
    logic [IDX_W-1:0] wr_idx, pt_idx;
    logic [7:0]       wr_val;
    logic [4:0]       used_raw;
    logic [4:0]       idx_next;

    assign n_used = (i_digit_count > 5'(DIGITS)) ? 5'(DIGITS) : i_digit_count;
    assign o_status.digits_used = n_used;

    always_comb begin
        eff_cur  = r_cursor;
        eff_org  = r_origin;
        eff_ovf  = r_ovf;
        n_cursor = r_cursor;
        n_origin = r_origin;
        n_ovf    = r_ovf;
        wr_en    = 1'b0;
        pt_en    = 1'b0;
        clr      = 1'b0;
        wr_val   = seg_lookup(i_in_data.character);
        wr_idx   = r_cursor[IDX_W-1:0];
        pos      = r_cursor;
        if (i_cmd.apply) begin
            unique case (i_in_data.op)
                OP_WRITE: begin
                    if (i_in_data.first_of_string) begin
                        eff_cur = {1'b0, i_in_data.start_position};
                        eff_org = i_in_data.start_position;
                        eff_ovf = 1'b0;
                    end
                    n_cursor = eff_cur;
                    n_origin = eff_org;
                    n_ovf    = eff_ovf;
                    wr_idx   = eff_cur[IDX_W-1:0];
                    pos      = (eff_cur != {1'b0, eff_org} && eff_cur != 5'd0) ?
                               eff_cur - 5'd1 : eff_cur;
                    if (!eff_ovf) begin
                        if (i_in_data.character == POINT_CH) begin
                            pt_en    = (pos < n_used);
                            n_cursor = pos + 5'd1;
                        end else if (eff_cur >= n_used) begin
                            n_ovf = 1'b1;
                        end else begin
                            wr_en    = 1'b1;
                            n_cursor = eff_cur + 5'd1;
                        end
                    end
                end
                OP_CLEAR: begin
                    clr = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    assign pt_idx = pos[IDX_W-1:0];

    assign used_raw = (n_cursor >= {1'b0, n_origin}) ? n_cursor - {1'b0, n_origin} : 5'd0;
    assign idx_next = 5'(i_cmd.idx) + 5'd1;

    always_comb begin
        n_out              = r_out;
        if (i_cmd.load) begin
            n_out.is_byte      = 1'b1;
            n_out.send_byte    = 8'h00;
            n_out.begins_frame = 1'b0;
            n_out.ends_frame   = 1'b0;
            n_out.last         = 1'b0;
            n_out.chars_used   = (used_raw > 5'd16) ? 5'd16 : used_raw;
            n_out.too_long     = n_ovf;
            unique case (i_cmd.kind)
                K_ACK: begin
                    n_out.is_byte = 1'b0;
                    n_out.last    = 1'b1;
                end
                K_DATA: begin
                    n_out.send_byte    = CMD_DATA;
                    n_out.begins_frame = 1'b1;
                    n_out.ends_frame   = 1'b1;
                end
                K_ADDR: begin
                    n_out.send_byte    = CMD_ADDR;
                    n_out.begins_frame = 1'b1;
                    n_out.ends_frame   = (n_used == 5'd0);
                end
                K_DIGIT: begin
                    n_out.send_byte  = r_digit[i_cmd.idx];
                    n_out.ends_frame = (idx_next == n_used);
                end
                K_CTRL: begin
                    n_out.send_byte    = CMD_CTRL + ({5'd0, i_brightness} | CTRL_ON);
                    n_out.begins_frame = 1'b1;
                    n_out.ends_frame   = 1'b1;
                    n_out.last         = 1'b1;
                end
                default: begin
                    n_out.is_byte = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || clr) begin
            for (int i = 0; i < DIGITS; i++) begin
                r_digit[i] <= '0;
            end
        end else if (wr_en) begin
            r_digit[wr_idx] <= wr_val;
        end else if (pt_en) begin
            r_digit[pt_idx][7] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_origin <= '0;
            r_ovf    <= 1'b0;
        end else begin
            r_cursor <= n_cursor;
            r_origin <= n_origin;
            r_ovf    <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_data = r_out;

endmodule

### rtl/seven_segment_text_display_controller_core.sv
// Top level of the seven-segment text display controller: configuration registers and wiring.
// Depends on sstd_pkg, sstd_ctrl and sstd_datapath.
//
// A character write, a clear or an unknown operation gives one acknowledgment transfer.
// A refresh gives 3 + n byte transfers, n being the digits in
// use, one per cycle while the output side does not stall; the sequencer walks the digit
// buffer one entry per cycle, and no new item is taken until the control byte is loaded.
// Configuration lives at byte address 0 (digit count) and 4 (brightness).
module seven_segment_text_display_controller_core import sstd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0] r_digit_count;
    logic [2:0] r_brightness;
    logic       cfg_wr;
    t_cmd       cmd;
    t_status    status;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= DIGIT_COUNT_RST;
            r_brightness  <= BRIGHTNESS_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_DIGIT_COUNT) begin
                r_digit_count <= pwdata[4:0];
            end else begin
                r_brightness <= pwdata[2:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_DIGIT_COUNT) begin
            prdata = {27'd0, r_digit_count};
        end else begin
            prdata = {29'd0, r_brightness};
        end
    end

    sstd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_op        (i_in_data.op),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sstd_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_cmd         (cmd),
        .i_digit_count (r_digit_count),
        .i_brightness  (r_brightness),
        .o_status      (status),
        .o_out_data    (o_out_data)
    );

endmodule
